FILE: rtl/core/wpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, result codes and mark tables for the 16-bit PCM WAV deframer.
// No dependencies; used by every module of the block.
package wpd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Header error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RIFF      = 3'd1;
    localparam logic [2:0] ERR_WAVE      = 3'd2;
    localparam logic [2:0] ERR_FMT_MARK  = 3'd3;
    localparam logic [2:0] ERR_FMT_SIZE  = 3'd4;
    localparam logic [2:0] ERR_FMT_TYPE  = 3'd5;
    localparam logic [2:0] ERR_CHANNELS  = 3'd6;
    localparam logic [2:0] ERR_BIT_DEPTH = 3'd7;

    // Mark selectors.
    localparam logic [1:0] MARK_RIFF = 2'd0;
    localparam logic [1:0] MARK_WAVE = 2'd1;
    localparam logic [1:0] MARK_FMT  = 2'd2;
    localparam logic [1:0] MARK_DATA = 2'd3;

    // Input request: one file byte.
    typedef struct packed {
        logic       start_req;
        logic [7:0] file_byte;
    } wpd_in_t;

    // Result item.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [14:0]        channel;
        logic               frame_end;
        logic [2:0]         error_code;
    } wpd_out_t;

    // Expected byte of a four-character mark.
    function automatic logic [7:0] mark_byte(input logic [1:0] which, input logic [1:0] idx);
        logic [31:0] word;
        case (which)
            MARK_RIFF: word = "RIFF";
            MARK_WAVE: word = "WAVE";
            MARK_FMT:  word = "fmt ";
            default:   word = "data";
        endcase
        case (idx)
            2'd0:    mark_byte = word[31:24];
            2'd1:    mark_byte = word[23:16];
            2'd2:    mark_byte = word[15:8];
            default: mark_byte = word[7:0];
        endcase
    endfunction

endpackage

FILE: rtl/core/wav_pcm16_deframer_unit.sv
`timescale 1ns / 1ps
// Deframer for 16-bit PCM WAV files arriving one byte per request.
// The src channel carries one file byte and a start_req flag; start_req marks byte 0 of a
// new file and restarts parsing. The res channel carries samples tagged with their
// channel and frame end, header errors with their code, and the end-of-stream mark.
// Both channels use valid/stall: a request moves at a clock edge with valid high and
// stall low.
// Throughput: one byte per cycle while src_stall is low. All parsing of a byte is done in
// the cycle it is taken, between the parser state registers and the result register.
// A result is registered at the edge that takes its byte, in the result register or the skid entry.
// When the receiver stalls, one further result is held in a skid entry; src_stall rises
// only once that entry is full, and bytes that give no result need it free as well.
// Reset (rst_n low, asynchronous) returns the parser to the start of the header and
// empties the result register and skid entry; the first byte after reset is byte 0.
// After an error or the end mark, bytes are dropped until the next start_req.
// Depends on wpd_pkg, wpd_parser and wpd_out_skid.
module wav_pcm16_deframer_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  wpd_pkg::wpd_in_t  src_data,
    output logic              res_valid,
    input  logic              res_stall,
    output wpd_pkg::wpd_out_t res_data
);

    logic              accept;
    logic              push;
    wpd_pkg::wpd_out_t push_data;
    logic              full;

    assign src_stall = full;
    assign accept    = src_valid && !full;

    // Parser state and next-state logic.
    wpd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (src_data),
        .res_push (push),
        .res      (push_data)
    );

    // Result register and skid entry.
    wpd_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && accept),
        .push_data (push_data),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef SYNTHESIS
    // The input is only held off while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n) src_stall |-> res_valid)
        else $error("src_stall high with no result waiting");

    // An error result always carries a code, and other kinds carry none.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.kind == wpd_pkg::KIND_ERROR)
                       == (res_data.error_code != wpd_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // Only the three defined kinds are produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.kind == wpd_pkg::KIND_SAMPLE
                       || res_data.kind == wpd_pkg::KIND_ERROR
                       || res_data.kind == wpd_pkg::KIND_END))
        else $error("undefined result kind");
`endif

endmodule

FILE: rtl/core/wpd_parser.sv
`timescale 1ns / 1ps
// Byte-wise RIFF/WAVE header and chunk parser state with its next-state logic.
// Depends on wpd_pkg for the request and result types and the codes.
module wpd_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  wpd_pkg::wpd_in_t req,
    output logic             res_push,
    output wpd_pkg::wpd_out_t res
);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_PAD  = 3'd1;
    localparam logic [2:0] PH_CHK  = 3'd2;
    localparam logic [2:0] PH_BND  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;
    localparam logic [2:0] PH_ERR  = 3'd7;

    localparam logic [32:0] POS_MAX = {33{1'b1}};

    logic [2:0]  phase_reg, phase_next, cur_phase;
    logic [5:0]  hc_reg, hc_next, cur_hc;
    logic [31:0] shift_reg, shift_next, cur_shift;
    logic        mm_reg, mm_next, cur_mm;
    logic [31:0] rem_reg, rem_next, cur_rem;
    logic [32:0] pos_reg, pos_next, cur_pos;
    logic [31:0] riff_reg, riff_next, cur_riff;
    logic [14:0] cc_reg, cc_next, cur_cc;
    logic [14:0] ci_reg, ci_next, cur_ci;
    logic [7:0]  low_reg, low_next, cur_low;
    logic        odd_reg, odd_next, cur_odd;
    logic        ext_reg, ext_next, cur_ext;

    logic [7:0]  b;
    logic [31:0] shift_take;
    logic [32:0] pos_take;
    logic [15:0] half;
    logic [5:0]  hc_inc;
    logic [5:0]  n_eff;
    logic [1:0]  which;
    logic        mm_upd;
    logic [31:0] rem_dec;
    logic        frame_short;
    logic [15:0] ci_inc;
    logic        last;
    logic        at_end;
    logic [2:0]  err;

    assign b = req.file_byte;

    // A start request clears all state before its byte is parsed.
    always_comb
    begin
        if (req.start_req)
        begin
            cur_phase = PH_HDR;
            cur_hc    = '0;
            cur_shift = '0;
            cur_mm    = 1'b1;
            cur_rem   = '0;
            cur_pos   = '0;
            cur_riff  = '0;
            cur_cc    = '0;
            cur_ci    = '0;
            cur_low   = '0;
            cur_odd   = 1'b0;
            cur_ext   = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_hc    = hc_reg;
            cur_shift = shift_reg;
            cur_mm    = mm_reg;
            cur_rem   = rem_reg;
            cur_pos   = pos_reg;
            cur_riff  = riff_reg;
            cur_cc    = cc_reg;
            cur_ci    = ci_reg;
            cur_low   = low_reg;
            cur_odd   = odd_reg;
            cur_ext   = ext_reg;
        end
    end

    // Terms shared by several phases.
    always_comb
    begin
        shift_take  = {b, cur_shift[31:8]};
        pos_take    = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 33'd1;
        half        = shift_take[31:16];
        hc_inc      = cur_hc + 6'd1;
        n_eff       = (cur_phase == PH_BND) ? 6'd0 : cur_hc;
        if (cur_phase != PH_HDR)
        begin
            which = wpd_pkg::MARK_DATA;
        end
        else if (cur_hc < 6'd8)
        begin
            which = wpd_pkg::MARK_RIFF;
        end
        else if (cur_hc < 6'd12)
        begin
            which = wpd_pkg::MARK_WAVE;
        end
        else
        begin
            which = wpd_pkg::MARK_FMT;
        end
        mm_upd      = ((n_eff[1:0] == 2'd0) ? 1'b1 : cur_mm)
                      & (b == wpd_pkg::mark_byte(which, n_eff[1:0]));
        rem_dec     = (cur_rem != 32'd0) ? cur_rem - 32'd1 : cur_rem;
        frame_short = !cur_odd && (cur_ci == 15'd0)
                      && (cur_rem < {16'd0, cur_cc, 1'b0});
        ci_inc      = {1'b0, cur_ci} + 16'd1;
        last        = (ci_inc >= {1'b0, cur_cc});
        at_end      = (cur_pos >= ({1'b0, cur_riff} + 33'd8));
    end

    // Next state and result for one accepted byte.
    always_comb
    begin
        phase_next = cur_phase;
        hc_next    = cur_hc;
        shift_next = cur_shift;
        mm_next    = cur_mm;
        rem_next   = cur_rem;
        pos_next   = cur_pos;
        riff_next  = cur_riff;
        cc_next    = cur_cc;
        ci_next    = cur_ci;
        low_next   = cur_low;
        odd_next   = cur_odd;
        ext_next   = cur_ext;
        err        = wpd_pkg::ERR_NONE;
        res_push   = 1'b0;
        res        = '0;

        unique case (cur_phase) inside
            PH_HDR:
            begin
                shift_next = shift_take;
                pos_next   = pos_take;
                hc_next    = hc_inc;
                if (cur_hc < 6'd4)
                begin
                    mm_next = mm_upd;
                    if (cur_hc[1:0] == 2'd3 && !mm_upd)
                    begin
                        err = wpd_pkg::ERR_RIFF;
                    end
                end
                else if (cur_hc == 6'd7)
                begin
                    riff_next = shift_take;
                end
                else if (cur_hc >= 6'd8 && cur_hc < 6'd12)
                begin
                    mm_next = mm_upd;
                    if (cur_hc[1:0] == 2'd3 && !mm_upd)
                    begin
                        err = wpd_pkg::ERR_WAVE;
                    end
                end
                else if (cur_hc >= 6'd12 && cur_hc < 6'd16)
                begin
                    mm_next = mm_upd;
                    if (cur_hc[1:0] == 2'd3 && !mm_upd)
                    begin
                        err = wpd_pkg::ERR_FMT_MARK;
                    end
                end
                else if (cur_hc == 6'd19)
                begin
                    if (shift_take != 32'd16 && shift_take != 32'd18)
                    begin
                        err = wpd_pkg::ERR_FMT_SIZE;
                    end
                    ext_next = (shift_take == 32'd18);
                end
                else if (cur_hc == 6'd21)
                begin
                    if (half != 16'd1)
                    begin
                        err = wpd_pkg::ERR_FMT_TYPE;
                    end
                end
                else if (cur_hc == 6'd23)
                begin
                    if (half == 16'd0 || half[15])
                    begin
                        err = wpd_pkg::ERR_CHANNELS;
                    end
                    else
                    begin
                        cc_next = half[14:0];
                    end
                end
                else if (cur_hc >= 6'd35)
                begin
                    if (half != 16'd16)
                    begin
                        err = wpd_pkg::ERR_BIT_DEPTH;
                    end
                    hc_next    = '0;
                    phase_next = cur_ext ? PH_PAD : PH_CHK;
                end
                if (err != wpd_pkg::ERR_NONE)
                begin
                    phase_next     = PH_ERR;
                    res_push       = 1'b1;
                    res.kind       = wpd_pkg::KIND_ERROR;
                    res.error_code = err;
                end
            end
            PH_PAD:
            begin
                shift_next = shift_take;
                pos_next   = pos_take;
                hc_next    = hc_inc;
                if (hc_inc >= 6'd2)
                begin
                    hc_next    = '0;
                    phase_next = PH_CHK;
                end
            end
            PH_BND, PH_CHK:
            begin
                if (cur_phase == PH_BND && at_end)
                begin
                    phase_next = PH_DONE;
                    res_push   = 1'b1;
                    res.kind   = wpd_pkg::KIND_END;
                end
                else
                begin
                    // One byte of a chunk header: mark, then size.
                    shift_next = shift_take;
                    pos_next   = pos_take;
                    hc_next    = n_eff + 6'd1;
                    if (n_eff < 6'd4)
                    begin
                        mm_next = mm_upd;
                    end
                    if (n_eff >= 6'd7)
                    begin
                        hc_next  = '0;
                        rem_next = shift_take;
                        if (cur_mm)
                        begin
                            ci_next    = '0;
                            odd_next   = 1'b0;
                            phase_next = (shift_take != 32'd0) ? PH_DATA : PH_BND;
                        end
                        else
                        begin
                            phase_next = (shift_take != 32'd0) ? PH_SKIP : PH_BND;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                shift_next = shift_take;
                pos_next   = pos_take;
                rem_next   = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_BND;
                end
            end
            PH_DATA:
            begin
                shift_next = shift_take;
                pos_next   = pos_take;
                if (frame_short)
                begin
                    phase_next = PH_SKIP;
                end
                else if (!cur_odd)
                begin
                    low_next = b;
                    odd_next = 1'b1;
                end
                else
                begin
                    res_push      = 1'b1;
                    res.kind      = wpd_pkg::KIND_SAMPLE;
                    res.sample    = $signed({b, cur_low});
                    res.channel   = cur_ci;
                    res.frame_end = last;
                    odd_next      = 1'b0;
                    ci_next       = last ? 15'd0 : ci_inc[14:0];
                end
                rem_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_BND;
                end
            end
            PH_DONE, PH_ERR:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            hc_reg    <= '0;
            mm_reg    <= 1'b1;
            rem_reg   <= '0;
            pos_reg   <= '0;
            riff_reg  <= '0;
            cc_reg    <= '0;
            ci_reg    <= '0;
            odd_reg   <= 1'b0;
            ext_reg   <= 1'b0;
            shift_reg <= '0;
            low_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            mm_reg    <= mm_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            riff_reg  <= riff_next;
            cc_reg    <= cc_next;
            ci_reg    <= ci_next;
            odd_reg   <= odd_next;
            ext_reg   <= ext_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
        end
    end

endmodule

FILE: rtl/core/wpd_out_skid.sv
`timescale 1ns / 1ps
// Result register with one skid entry, so the parser keeps taking bytes while a result waits.
// Depends on wpd_pkg for the result type.
module wpd_out_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wpd_pkg::wpd_out_t push_data,
    output logic              full,
    output logic              res_valid,
    input  logic              res_stall,
    output wpd_pkg::wpd_out_t res_data
);

    logic              main_valid_reg;
    wpd_pkg::wpd_out_t main_data_reg;
    logic              skid_valid_reg;
    wpd_pkg::wpd_out_t skid_data_reg;
    logic              pop;

    assign pop       = main_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res_data  = main_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload moves; no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

FILE: tb/wav_pcm16_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for wav_pcm16_deframer_unit: byte requests in, results checked
// in order against a cycle-free predictor of the parser. Depends on wpd_pkg and the RTL.
module wav_pcm16_deframer_unit_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 8;

    // Phases of the predictor's own parser.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FMT_PAD,
        PH_CHUNK_HDR,
        PH_BOUNDARY,
        PH_DATA,
        PH_SKIP,
        PH_DONE,
        PH_ERROR
    } parse_phase_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_stall;
    wpd_pkg::wpd_in_t  src_data = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    wpd_pkg::wpd_out_t res_data;

    wav_pcm16_deframer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Predictor state.
    parse_phase_t ph;
    logic [5:0]   hdr_cnt;
    logic [31:0]  shift_word;
    logic         mark_ok;
    logic [31:0]  body_left;
    logic [32:0]  byte_pos;
    logic [31:0]  riff_len;
    logic [14:0]  chan_total;
    logic [14:0]  chan_idx;
    logic [7:0]   lo_byte;
    logic         hi_next;
    logic         fmt_ext;

    wpd_pkg::wpd_out_t expected_results[$];
    logic [7:0]        file_buf[$];

    bit           idle_on = 1'b1;
    int           fail_cnt = 0;
    int           bytes_sent = 0;
    int           files_sent = 0;
    int           n_samples = 0;
    int           n_errors = 0;
    int           n_ends = 0;
    int           cycle_cnt = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void restart_parser();
        ph         = PH_HEADER;
        hdr_cnt    = '0;
        shift_word = '0;
        mark_ok    = 1'b1;
        body_left  = '0;
        byte_pos   = '0;
        riff_len   = '0;
        chan_total = '0;
        chan_idx   = '0;
        lo_byte    = '0;
        hi_next    = 1'b0;
        fmt_ext    = 1'b0;
    endfunction

    // Little-endian shift in; the byte count saturates at its full width.
    function automatic void shift_in(input logic [7:0] b);
        shift_word = {b, shift_word[31:8]};
        if (byte_pos != {33{1'b1}})
            byte_pos = byte_pos + 33'd1;
    endfunction

    function automatic logic [7:0] mark_char(input logic [1:0] which, input logic [1:0] idx);
        logic [31:0] word;
        case (which)
            wpd_pkg::MARK_RIFF: word = "RIFF";
            wpd_pkg::MARK_WAVE: word = "WAVE";
            wpd_pkg::MARK_FMT:  word = "fmt ";
            default:            word = "data";
        endcase
        word = word << (8 * idx);
        return word[31:24];
    endfunction

    // Running mark compare; true when the fourth byte leaves the mark unmatched.
    function automatic logic mark_bad(input logic [1:0] which, input logic [1:0] idx,
                                      input logic [7:0] b);
        if (idx == 2'd0)
            mark_ok = 1'b1;
        mark_ok = mark_ok && (b == mark_char(which, idx));
        return (idx == 2'd3) && !mark_ok;
    endfunction

    function automatic void queue_result(input logic [1:0] k, input logic [15:0] s,
                                         input logic [14:0] ch, input logic fe,
                                         input logic [2:0] e);
        wpd_pkg::wpd_out_t r;
        r.kind       = k;
        r.sample     = s;
        r.channel    = ch;
        r.frame_end  = fe;
        r.error_code = e;
        expected_results.push_back(r);
    endfunction

    function automatic void chunk_hdr_byte(input logic [7:0] b);
        logic [5:0] n;
        n = hdr_cnt;
        shift_in(b);
        hdr_cnt = hdr_cnt + 6'd1;
        if (n < 6'd4)
            void'(mark_bad(wpd_pkg::MARK_DATA, n[1:0], b));
        if (n >= 6'd7)
        begin
            hdr_cnt   = '0;
            body_left = shift_word;
            if (mark_ok)
            begin
                chan_idx = '0;
                hi_next  = 1'b0;
            end
            if (shift_word == 32'd0)
                ph = PH_BOUNDARY;
            else if (mark_ok)
                ph = PH_DATA;
            else
                ph = PH_SKIP;
        end
    endfunction

    function automatic void body_step();
        if (body_left != 32'd0)
            body_left = body_left - 32'd1;
        if (body_left == 32'd0)
            ph = PH_BOUNDARY;
    endfunction

    // Works out the result, if any, of one accepted byte request.
    function automatic void predict_byte(input wpd_pkg::wpd_in_t req);
        logic [7:0]  b;
        logic [5:0]  n;
        logic [15:0] half;
        logic [2:0]  err;
        logic        last;
        b = req.file_byte;
        if (req.start_req)
            restart_parser();
        case (ph)
            PH_HEADER:
            begin
                n = hdr_cnt;
                shift_in(b);
                hdr_cnt = hdr_cnt + 6'd1;
                half = shift_word[31:16];
                err  = wpd_pkg::ERR_NONE;
                if (n < 6'd4)
                begin
                    if (mark_bad(wpd_pkg::MARK_RIFF, n[1:0], b))
                        err = wpd_pkg::ERR_RIFF;
                end
                else if (n == 6'd7)
                    riff_len = shift_word;
                else if (n >= 6'd8 && n < 6'd12)
                begin
                    if (mark_bad(wpd_pkg::MARK_WAVE, n[1:0], b))
                        err = wpd_pkg::ERR_WAVE;
                end
                else if (n >= 6'd12 && n < 6'd16)
                begin
                    if (mark_bad(wpd_pkg::MARK_FMT, n[1:0], b))
                        err = wpd_pkg::ERR_FMT_MARK;
                end
                else if (n == 6'd19)
                begin
                    if (shift_word != 32'd16 && shift_word != 32'd18)
                        err = wpd_pkg::ERR_FMT_SIZE;
                    fmt_ext = (shift_word == 32'd18);
                end
                else if (n == 6'd21)
                begin
                    if (half != 16'd1)
                        err = wpd_pkg::ERR_FMT_TYPE;
                end
                else if (n == 6'd23)
                begin
                    if (half == 16'd0 || half[15])
                        err = wpd_pkg::ERR_CHANNELS;
                    else
                        chan_total = half[14:0];
                end
                else if (n >= 6'd35)
                begin
                    if (half != 16'd16)
                        err = wpd_pkg::ERR_BIT_DEPTH;
                    hdr_cnt = '0;
                    ph = fmt_ext ? PH_FMT_PAD : PH_CHUNK_HDR;
                end
                if (err != wpd_pkg::ERR_NONE)
                begin
                    ph = PH_ERROR;
                    queue_result(wpd_pkg::KIND_ERROR, '0, '0, 1'b0, err);
                end
            end
            PH_FMT_PAD:
            begin
                shift_in(b);
                hdr_cnt = hdr_cnt + 6'd1;
                if (hdr_cnt >= 6'd2)
                begin
                    hdr_cnt = '0;
                    ph = PH_CHUNK_HDR;
                end
            end
            PH_BOUNDARY:
            begin
                // The end test applies at every boundary after the first chunk header.
                if (byte_pos >= {1'b0, riff_len} + 33'd8)
                begin
                    ph = PH_DONE;
                    queue_result(wpd_pkg::KIND_END, '0, '0, 1'b0, wpd_pkg::ERR_NONE);
                end
                else
                begin
                    hdr_cnt = '0;
                    chunk_hdr_byte(b);
                end
            end
            PH_CHUNK_HDR:
                chunk_hdr_byte(b);
            PH_SKIP:
            begin
                shift_in(b);
                body_step();
            end
            PH_DATA:
            begin
                shift_in(b);
                // A frame that cannot complete within the chunk is skipped whole.
                if (!hi_next && chan_idx == 15'd0 && body_left < {16'd0, chan_total, 1'b0})
                    ph = PH_SKIP;
                else if (!hi_next)
                begin
                    lo_byte = b;
                    hi_next = 1'b1;
                end
                else
                begin
                    last = ({1'b0, chan_idx} + 16'd1) >= {1'b0, chan_total};
                    queue_result(wpd_pkg::KIND_SAMPLE, {b, lo_byte}, chan_idx, last,
                                 wpd_pkg::ERR_NONE);
                    hi_next  = 1'b0;
                    chan_idx = last ? 15'd0 : chan_idx + 15'd1;
                end
                body_step();
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------

    function automatic void put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            file_buf.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void put_mark(input logic [31:0] m);
        for (int i = 3; i >= 0; i--)
            file_buf.push_back(m[8 * i +: 8]);
    endfunction

    function automatic void put_header(input logic [31:0] riff, input logic [31:0] fmt_len,
                                       input logic [15:0] fmt_code, input logic [15:0] chans,
                                       input logic [15:0] depth);
        put_mark("RIFF");
        put_le(riff, 4);
        put_mark("WAVE");
        put_mark("fmt ");
        put_le(fmt_len, 4);
        put_le({16'd0, fmt_code}, 2);
        put_le({16'd0, chans}, 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le({15'd0, chans, 1'b0}, 2);
        put_le({16'd0, depth}, 2);
        if (fmt_len == 32'd18)
            put_le($urandom, 2);
    endfunction

    function automatic void put_chunk(input logic [31:0] m, input logic [31:0] size,
                                      input int body);
        put_mark(m);
        put_le(size, 4);
        repeat (body) file_buf.push_back(8'($urandom));
    endfunction

    function automatic void fix_riff(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_buf[4 + i] = v[8 * i +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Sends one byte request, with a random gap before it when idling is on.
    task automatic send_byte(input logic start, input logic [7:0] b);
        wpd_pkg::wpd_in_t req;
        req.start_req = start;
        req.file_byte = b;
        if (idle_on && $urandom_range(99) < 13)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= req;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        predict_byte(req);
        bytes_sent++;
    endtask

    // Holds requests back until every expected result has come out.
    task automatic drain_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_file(input logic with_start, input bit may_pause);
        int pause_at;
        pause_at = -1;
        if (may_pause && $urandom_range(99) < 5)
            pause_at = $urandom_range(1, file_buf.size() - 1);
        foreach (file_buf[i])
        begin
            if (i == pause_at)
                drain_results();
            send_byte((i == 0) ? with_start : 1'b0, file_buf[i]);
        end
        files_sent++;
        file_buf.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mono file straight after reset with no start flag; samples at both extremes.
    task automatic test_plain_file();
        put_header(32'd40, 32'd16, 16'd1, 16'd1, 16'd16);
        put_mark("data");
        put_le(32'd4, 4);
        put_le(32'h8000, 2);
        put_le(32'h7fff, 2);
        // The first byte past the end gives the end mark; the next one is dropped.
        file_buf.push_back(8'hff);
        file_buf.push_back(8'h00);
        send_file(1'b0, 1'b0);
        drain_results();
    endtask

    // Every header error, once cut short at the failing field and once sent whole with
    // another variant of the fault; a bad RIFF mark also carries a bad WAVE mark.
    task automatic test_header_errors();
        int field_end;
        int cut;
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int code = wpd_pkg::ERR_RIFF; code <= wpd_pkg::ERR_BIT_DEPTH; code++)
            begin
                field_end = 36;
                put_header(32'd40, 32'd16, 16'd1, 16'd2, 16'd16);
                case (code[2:0])
                    wpd_pkg::ERR_RIFF:
                    begin
                        field_end = 4;
                        file_buf[3] = pass ? 8'h00 : "X";
                        file_buf[8] = "w";
                    end
                    wpd_pkg::ERR_WAVE:
                    begin
                        field_end = 12;
                        file_buf[11] = pass ? " " : "F";
                    end
                    wpd_pkg::ERR_FMT_MARK:
                    begin
                        field_end = 16;
                        file_buf[pass ? 15 : 12] = 8'h00;
                    end
                    wpd_pkg::ERR_FMT_SIZE:
                    begin
                        field_end = 20;
                        if (pass)
                            file_buf[18] = 8'h01;
                        else
                            file_buf[16] = 8'd17;
                    end
                    wpd_pkg::ERR_FMT_TYPE:
                    begin
                        field_end = 22;
                        if (pass)
                            file_buf[21] = 8'h80;
                        else
                            file_buf[20] = 8'd3;
                    end
                    wpd_pkg::ERR_CHANNELS:
                    begin
                        // Zero channels, then the most negative count.
                        field_end = 24;
                        file_buf[22] = 8'h00;
                        file_buf[23] = pass ? 8'h80 : 8'h00;
                    end
                    wpd_pkg::ERR_BIT_DEPTH:
                    begin
                        file_buf[34] = pass ? 8'h10 : 8'd8;
                        file_buf[35] = pass ? 8'h10 : 8'h00;
                    end
                    default:
                    begin
                    end
                endcase
                cut = pass ? 36 : field_end;
                while (file_buf.size() > cut)
                    void'(file_buf.pop_back());
                // Bytes after an error are ignored until the next start.
                repeat (3) file_buf.push_back(8'($urandom));
                send_file(1'b1, 1'b0);
            end
        end
        drain_results();
    endtask

    // Chunk walking: padded fmt header, odd skipped chunk, partial frame, empty first data
    // chunk, a near-miss data mark, an understated RIFF size and the largest sizes.
    task automatic test_chunk_walk();
        // Stereo with fmt pad; odd LIST chunk, then two frames and a partial one.
        put_header(32'd0, 32'd18, 16'd1, 16'd2, 16'd16);
        put_chunk("LIST", 32'd3, 3);
        put_chunk("data", 32'd10, 10);
        fix_riff(file_buf.size() - 8);
        file_buf.push_back(8'($urandom));
        send_file(1'b1, 1'b0);

        // Empty first data chunk, a later data chunk, then a near-miss mark skipped.
        put_header(32'd0, 32'd16, 16'd1, 16'd1, 16'd16);
        put_chunk("data", 32'd0, 0);
        put_chunk("data", 32'd4, 4);
        put_chunk("datb", 32'd2, 2);
        fix_riff(file_buf.size() - 8);
        file_buf.push_back(8'($urandom));
        send_file(1'b1, 1'b0);

        // Understated RIFF size: ends at the first boundary after the empty chunk.
        put_header(32'd4, 32'd16, 16'd1, 16'd1, 16'd16);
        put_chunk("data", 32'd0, 0);
        put_chunk("data", 32'd4, 4);
        send_file(1'b1, 1'b0);

        // Largest RIFF and chunk sizes; abandoned mid-chunk by the next start.
        put_header(32'hffff_ffff, 32'd16, 16'd1, 16'd1, 16'd16);
        put_chunk("data", 32'hffff_ffff, 6);
        send_file(1'b1, 1'b0);

        // Largest channel count: the frame cannot fit, so the chunk gives nothing.
        put_header(32'd0, 32'd16, 16'd1, 16'h7fff, 16'd16);
        put_chunk("data", 32'd6, 6);
        put_chunk("data", 32'd0, 0);
        fix_riff(file_buf.size() - 8);
        file_buf.push_back(8'($urandom));
        send_file(1'b1, 1'b0);
        drain_results();
    endtask

    // Mostly well-formed files with random content, some damaged, some pure noise.
    task automatic test_random_files(input int byte_goal);
        int          goal_end;
        int          sel;
        int          chans;
        int          body;
        int          pos;
        int          total;
        logic [31:0] fmt_len;
        logic [31:0] m;
        logic [31:0] riff;
        goal_end = bytes_sent + byte_goal;
        while (bytes_sent < goal_end)
        begin
            if ($urandom_range(99) < 6)
            begin
                repeat ($urandom_range(4, 40)) file_buf.push_back(8'($urandom));
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    chans = $urandom_range(1, 4);
                else if (sel < 90)
                    chans = $urandom_range(5, 12);
                else
                    chans = $urandom_range(13, 32767);
                fmt_len = ($urandom_range(99) < 30) ? 32'd18 : 32'd16;
                put_header(32'd0, fmt_len, 16'd1, 16'(chans), 16'd16);
                repeat ($urandom_range(1, 3))
                begin
                    sel = $urandom_range(99);
                    if (sel < 65)
                        m = "data";
                    else if (sel < 90)
                        m = $urandom;
                    else
                    begin
                        m = "data";
                        pos = $urandom_range(0, 3);
                        m[8 * pos +: 8] = m[8 * pos +: 8] ^ 8'h20;
                    end
                    if (chans <= 4 && $urandom_range(99) < 70)
                        body = 2 * chans * $urandom_range(0, 4);
                    else
                        body = $urandom_range(0, 24);
                    put_chunk(m, body, body);
                end
                total = file_buf.size() - 8;
                sel = $urandom_range(99);
                if (sel < 75)
                    riff = total;
                else if (sel < 85)
                    riff = $urandom_range(0, total - 1);
                else if (sel < 95)
                    riff = total + $urandom_range(1, 6);
                else
                    riff = 32'hffff_ffff;
                fix_riff(riff);
                repeat ($urandom_range(1, 2)) file_buf.push_back(8'($urandom));
                // Occasionally damage one header bit.
                if ($urandom_range(99) < 10)
                begin
                    pos = $urandom_range(0, 35);
                    file_buf[pos] = file_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            send_file($urandom_range(99) < 92, 1'b1);
        end
        drain_results();
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_files(60);
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        wpd_pkg::wpd_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", res_data.kind);
                fail_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res_data.kind);
                    fail_cnt++;
                end
                if (res_data.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, res_data.sample);
                    fail_cnt++;
                end
                if (res_data.channel !== want.channel)
                begin
                    $error("channel: expected %0d, got %0d", want.channel, res_data.channel);
                    fail_cnt++;
                end
                if (res_data.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end,
                           res_data.frame_end);
                    fail_cnt++;
                end
                if (res_data.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           res_data.error_code);
                    fail_cnt++;
                end
                case (want.kind)
                    wpd_pkg::KIND_SAMPLE: n_samples++;
                    wpd_pkg::KIND_ERROR:  n_errors++;
                    default:              n_ends++;
                endcase
            end
        end
        res_stall <= idle_on && ($urandom_range(99) < 21);
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        restart_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_file();
        test_header_errors();
        test_chunk_walk();
        test_back_to_back();
        test_random_files(30);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never came out", expected_results.size());
            fail_cnt++;
        end

        $display("run: %0d files in %0d byte requests over %0d cycles",
                 files_sent, bytes_sent, cycle_cnt);
        $display("run: checked %0d samples, %0d header errors, %0d stream ends; %0d mismatches",
                 n_samples, n_errors, n_ends, fail_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
